// File: design/text_to_integer_any_base_defines.svh
// ----------------------------------------------------------------------------
// text_to_integer_any_base_defines.svh
// assertion macros shared by the text to integer block
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_ANY_BASE_DEFINES_SVH
`define TEXT_TO_INTEGER_ANY_BASE_DEFINES_SVH

// property checked on every rising clk edge, off while rst_n is low
`define TTIAB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be seen
`define TTIAB_NEVER(label, expr, msg) \
    `TTIAB_ASSERT(label, !(expr), msg)

`endif

// File: design/ttiab_pkg.sv
// ----------------------------------------------------------------------------
// ttiab_pkg
// types, character codes and digit decode for the text to integer block
// ----------------------------------------------------------------------------
package ttiab_pkg;

    localparam int CHAR_W  = 8;
    localparam int RADIX_W = 6;
    localparam int VALUE_W = 64;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
    // above every legal radix, so it never counts as a digit
    localparam logic [RADIX_W-1:0] NO_DIGIT    = 6'd63;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_0     = 8'd48;
    localparam logic [CHAR_W-1:0] CH_9     = 8'd57;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'd122;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
        logic                      had_digits;
    } out_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_0 && c <= CH_9)
        begin
            d = RADIX_W'(c - CH_0);
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            d = RADIX_W'(c - CH_UA) + DIGIT_TEN;
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            d = RADIX_W'(c - CH_LA) + DIGIT_TEN;
        end
        return d;
    endfunction

endpackage

// File: design/text_to_integer_any_base.sv
// ----------------------------------------------------------------------------
// text_to_integer_any_base
// parses signed integer text one character per transaction in base 2..36
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_stall  in_data  (char_code, end_of_text)
//  out       output     out_valid/ out_stall out_data (value, saturated, had_digits)
//  radix     input      radix_we             radix_data
//
//  whitespace, sign, non-digit and end transactions are handled in the idle state
//  a digit goes through accept, 6 shift-add steps of the shared adder
//  (one per radix bit), then one range check against the signed limit
//  reset sets radix to 10 and clears the parse state, no clearing pass
//  an end transaction waits while a digit is in progress or the previous result is still held
//
`include "text_to_integer_any_base_defines.svh"

module text_to_integer_any_base
    import ttiab_pkg::*;
#(
    parameter int VALUE_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 radix_we,
    input  logic [RADIX_W-1:0]   radix_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data
);

    localparam int PW    = VALUE_BITS + RADIX_W;
    localparam int CNT_W = $clog2(RADIX_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RADIX_W - 1);
    localparam logic [PW-1:0]    TOP       = PW'(1) << (VALUE_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CHK
    } state_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_DIGITS,
        PH_STOP
    } phase_t;

    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [RADIX_W-1:0]      radix_reg, radix_next;
    logic                    neg_reg, neg_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    any_reg, any_next;
    logic                    clamped_reg, clamped_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [PW-1:0]           mcand_reg, mcand_next;
    logic [RADIX_W-1:0]      rbits_reg, rbits_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    out_t                    out_reg, out_next;

    logic                    in_fire;
    logic [RADIX_W-1:0]      digit;
    logic                    digit_ok;
    logic [PW-1:0]           lim;
    logic signed [VALUE_BITS-1:0] signed_val;

    assign in_stall  = (state_reg != S_IDLE)
                     || (in_data.end_of_text && out_valid_reg && out_stall);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign digit      = digit_of(in_data.char_code);
    assign digit_ok   = digit < radix_reg;
    assign lim        = neg_reg ? TOP : TOP - PW'(1);
    assign signed_val = any_reg ? (neg_reg ? -acc_reg : acc_reg) : '0;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        any_next       = any_reg;
        clamped_next   = clamped_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        rbits_next     = rbits_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // out-of-range bases are dropped
        if (radix_we && radix_data >= RADIX_MIN && radix_data <= RADIX_MAX)
        begin
            radix_next = radix_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.end_of_text)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.value      = VALUE_W'(signed_val);
                        out_next.saturated  = clamped_reg;
                        out_next.had_digits = any_reg;
                        phase_next          = PH_SPACE;
                        neg_next            = 1'b0;
                        acc_next            = '0;
                        any_next            = 1'b0;
                        clamped_next        = 1'b0;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_SPACE:
                            begin
                                if (is_space(in_data.char_code))
                                begin
                                    phase_next = PH_SPACE;
                                end
                                else if (in_data.char_code == CH_MINUS)
                                begin
                                    neg_next   = 1'b1;
                                    phase_next = PH_DIGITS;
                                end
                                else if (in_data.char_code == CH_PLUS)
                                begin
                                    phase_next = PH_DIGITS;
                                end
                                else if (!digit_ok)
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                            PH_DIGITS:
                            begin
                                if (!digit_ok)
                                begin
                                    phase_next = PH_STOP;
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase

                        // digit accepted: start acc * radix + digit
                        if (digit_ok && phase_reg != PH_STOP
                            && !(phase_reg == PH_SPACE
                                 && (is_space(in_data.char_code)
                                     || in_data.char_code == CH_MINUS
                                     || in_data.char_code == CH_PLUS)))
                        begin
                            any_next   = 1'b1;
                            prod_next  = PW'(digit);
                            mcand_next = PW'(acc_reg);
                            rbits_next = radix_reg;
                            cnt_next   = '0;
                            state_next = S_MUL;
                        end
                    end
                end
            end
            S_MUL:
            begin
                if (rbits_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next = mcand_reg << 1;
                rbits_next = rbits_reg >> 1;
                cnt_next   = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (prod_reg > lim)
                begin
                    acc_next     = lim[VALUE_BITS-1:0];
                    clamped_next = 1'b1;
                    phase_next   = PH_STOP;
                end
                else
                begin
                    acc_next   = prod_reg[VALUE_BITS-1:0];
                    phase_next = PH_DIGITS;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_SPACE;
            radix_reg     <= RADIX_RESET;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            any_reg       <= 1'b0;
            clamped_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            any_reg       <= any_next;
            clamped_reg   <= clamped_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        rbits_reg <= rbits_next;
        out_reg   <= out_next;
    end

    `TTIAB_ASSERT(a_busy_stalls, (state_reg != S_IDLE) |-> in_stall,
        "input taken while a digit is in progress")
    `TTIAB_ASSERT(a_acc_in_range, PW'(acc_reg) <= lim,
        "magnitude above the limit for its sign")
    `TTIAB_ASSERT(a_clamp_stops, clamped_reg |-> (phase_reg == PH_STOP && any_reg),
        "clamp without stop or without digit")
    `TTIAB_NEVER(a_radix_legal, radix_reg < RADIX_MIN || radix_reg > RADIX_MAX,
        "radix outside 2..36")

endmodule
